// ===== design/fts_pkg.sv =====
// Shared constants, types and the segment table of the frequency display decoder.
`default_nettype none
package fts_pkg;

  localparam int FREQ_W     = 34;
  localparam int DIG_W      = 4;
  localparam int NUM_DIGITS = 11;
  localparam int BCD_W      = NUM_DIGITS * DIG_W;
  localparam int PLACES     = 7;
  localparam int DROP_DIGITS = 3;
  localparam int SEG_W      = 7;

  localparam logic [SEG_W-1:0] SEG_DASH  = 7'h40;
  localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

  typedef struct packed {
    logic [BCD_W-1:0]  bcd;
    logic [FREQ_W-1:0] bin;
  } dd_word_t;

  typedef logic [PLACES-1:0][SEG_W-1:0] seg_row_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] digit);
    logic [SEG_W-1:0] seg;
    unique case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

// ===== design/fts_if.sv =====
// Valid/ready channel interfaces for frequency input and segment output.
`default_nettype none
interface fts_freq_if;
  logic                       valid;
  logic                       ready;
  logic [fts_pkg::FREQ_W-1:0] frequency_hz;

  modport source (output valid, output frequency_hz, input ready);
  modport sink   (input valid, input frequency_hz, output ready);
endinterface

interface fts_seg_if;
  logic                      valid;
  logic                      ready;
  logic [fts_pkg::SEG_W-1:0] seg_place_0;
  logic [fts_pkg::SEG_W-1:0] seg_place_1;
  logic [fts_pkg::SEG_W-1:0] seg_place_2;
  logic [fts_pkg::SEG_W-1:0] seg_place_3;
  logic [fts_pkg::SEG_W-1:0] seg_place_4;
  logic [fts_pkg::SEG_W-1:0] seg_place_5;
  logic [fts_pkg::SEG_W-1:0] seg_place_6;

  modport source (output valid, output seg_place_0, output seg_place_1, output seg_place_2,
                  output seg_place_3, output seg_place_4, output seg_place_5,
                  output seg_place_6, input ready);
  modport sink   (input valid, input seg_place_0, input seg_place_1, input seg_place_2,
                  input seg_place_3, input seg_place_4, input seg_place_5,
                  input seg_place_6, output ready);
endinterface
`default_nettype wire

// ===== design/fts_dd_cell.sv =====
// One shift-and-add-3 step of the binary to BCD conversion chain.
`default_nettype none
module fts_dd_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              valid_i,
  input  wire fts_pkg::dd_word_t word_i,
  output logic                   valid_o,
  output fts_pkg::dd_word_t      word_o
);

  logic                      valid_q;
  fts_pkg::dd_word_t         word_q, word_d;
  logic [fts_pkg::BCD_W-1:0] bcd_adj;

  always_comb begin
    for (int i = 0; i < fts_pkg::NUM_DIGITS; i++) begin
      if (word_i.bcd[i*fts_pkg::DIG_W +: fts_pkg::DIG_W] >= 4'd5) begin
        bcd_adj[i*fts_pkg::DIG_W +: fts_pkg::DIG_W] =
          word_i.bcd[i*fts_pkg::DIG_W +: fts_pkg::DIG_W] + 4'd3;
      end else begin
        bcd_adj[i*fts_pkg::DIG_W +: fts_pkg::DIG_W] =
          word_i.bcd[i*fts_pkg::DIG_W +: fts_pkg::DIG_W];
      end
    end
    word_d.bcd = {bcd_adj[fts_pkg::BCD_W-2:0], word_i.bin[fts_pkg::FREQ_W-1]};
    word_d.bin = {word_i.bin[fts_pkg::FREQ_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule
`default_nettype wire

// ===== design/fts_seg_enc.sv =====
// Picks the kilohertz digits, blanks leading zeros and maps them to segments; zero shows dashes.
`default_nettype none
module fts_seg_enc (
  input  wire logic [fts_pkg::BCD_W-1:0] bcd_i,
  output fts_pkg::seg_row_t              seg_o
);

  always_comb begin
    logic                      leading;
    logic [fts_pkg::DIG_W-1:0] digit;
    leading = 1'b1;
    for (int k = 0; k < fts_pkg::PLACES; k++) begin
      digit = bcd_i[(fts_pkg::DROP_DIGITS + fts_pkg::PLACES - 1 - k) * fts_pkg::DIG_W
                    +: fts_pkg::DIG_W];
      if (bcd_i == '0) begin
        seg_o[k] = fts_pkg::SEG_DASH;
      end else if (leading && digit == '0) begin
        seg_o[k] = fts_pkg::SEG_BLANK;
      end else begin
        leading  = 1'b0;
        seg_o[k] = fts_pkg::seg_of(digit);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/frequency_to_seven_segment_top.sv =====
// Top level of the frequency to seven-segment decoder: cell chain and output register.
//
// Usage:
//   freq_i carries a 34-bit frequency in hertz; seg_o carries seven segment
//   patterns (bit 0 = A .. bit 6 = G), leftmost place first, showing the
//   kilohertz value modulo 10^7 with leading zeros blanked; zero hertz shows
//   a dash in every place.
//   Each transfer on freq_i moves through a row of 34 conversion cells, one
//   input bit per cell, then the segment encoder and the output register.
//   Throughput is one item per cycle while seg_o is not stalled; the whole
//   row advances together. When the receiver stalls with a result waiting,
//   the row and freq_i.ready hold until seg_o.ready returns; a bubble ahead
//   of an empty output register keeps the row moving.
//   Reset clears all valid flags; no item is in flight afterwards and the
//   block takes input in the first cycle after reset.
`default_nettype none
module frequency_to_seven_segment_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fts_freq_if.sink  freq_i,
  fts_seg_if.source seg_o
);

  localparam int Stages = fts_pkg::FREQ_W;

  logic                        adv;
  logic [Stages:0]             valid_chain;
  fts_pkg::dd_word_t           word_chain [Stages+1];
  fts_pkg::seg_row_t           seg_row;
  fts_pkg::seg_row_t           seg_q;
  logic                        out_valid_q;

  assign adv          = !out_valid_q || seg_o.ready;
  assign freq_i.ready = adv;

  assign valid_chain[0]    = freq_i.valid;
  assign word_chain[0].bcd = '0;
  assign word_chain[0].bin = freq_i.frequency_hz;

  for (genvar s = 0; s < Stages; s++) begin : g_cell
    fts_dd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (valid_chain[s]),
      .word_i  (word_chain[s]),
      .valid_o (valid_chain[s+1]),
      .word_o  (word_chain[s+1])
    );
  end

  fts_seg_enc u_enc (
    .bcd_i (word_chain[Stages].bcd),
    .seg_o (seg_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= valid_chain[Stages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      seg_q <= seg_row;
    end
  end

  assign seg_o.valid       = out_valid_q;
  assign seg_o.seg_place_0 = seg_q[0];
  assign seg_o.seg_place_1 = seg_q[1];
  assign seg_o.seg_place_2 = seg_q[2];
  assign seg_o.seg_place_3 = seg_q[3];
  assign seg_o.seg_place_4 = seg_q[4];
  assign seg_o.seg_place_5 = seg_q[5];
  assign seg_o.seg_place_6 = seg_q[6];

  a_stall_holds_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(valid_chain[Stages:1]))
    else $error("cell row moved during output stall");

  a_last_cell_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && valid_chain[Stages] |=> out_valid_q)
    else $error("result from last cell lost");

  a_dash_all_places: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && seg_q[0] == fts_pkg::SEG_DASH |->
      seg_q[6] == fts_pkg::SEG_DASH && seg_q[3] == fts_pkg::SEG_DASH)
    else $error("partial dash display");

  a_units_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && seg_q[0] != fts_pkg::SEG_BLANK |-> seg_q[6] != fts_pkg::SEG_BLANK)
    else $error("units place blanked after a shown digit");

endmodule
`default_nettype wire
